FILE: rtl/mpc_pkg.sv
// Shared constants and types for the maximum intensity projection compositor.
// Used by the storage module and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mpc_pkg;

    localparam int VALUE_W  = 8;
    localparam int COORD_W  = 8;
    localparam int PLANE_W  = 6;
    localparam int PCOUNT_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam int DEF_GRID_WIDTH  = 256;
    localparam int DEF_GRID_HEIGHT = 256;
    localparam int MAX_PLANES      = 64;

    // Coordinates are 8 bits wide, so no more than 256 cells per axis are addressable.
    localparam int AXIS_CELLS_MAX = 1 << COORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_X_FIRST = 3'd0,
        CFG_WINDOW_X_LAST  = 3'd1,
        CFG_WINDOW_Y_FIRST = 3'd2,
        CFG_WINDOW_Y_LAST  = 3'd3,
        CFG_PLANE_COUNT    = 3'd4
    } cfg_index_t;

endpackage : mpc_pkg

`default_nettype wire

FILE: rtl/mpc_store.sv
// Byte store holding the running maximum of every window cell.
// One write port and one read port with registered read data; uses mpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpc_store
    import mpc_pkg::*;
#(
    parameter int ADDR_W = 16,
    parameter int DATA_W = VALUE_W
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read in the same cycle as a write to the same cell returns the old byte.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : mpc_store

`default_nettype wire

FILE: rtl/max_projection_composite.sv
// Maximum intensity projection compositor: accepts one sample item per clock while no
// stall holds the input, and produces at most one result item per sample, passed through
// the first stage, the compositing stage and the output register. The rate is set by the
// read-modify-write loop on the
// single-write-port cell store: the read is issued in the first stage, the maximum is
// formed and written back in the second, and a back-to-back hit on the same cell is
// served by forwarding the value being written. The store needs no clearing pass after
// reset; cells are defined once plane 0 has written them. Configuration writes are
// always taken and must be made while no sample is in flight. Uses mpc_pkg and mpc_store.
`timescale 1ns / 1ps
`default_nettype none

module max_projection_composite
    import mpc_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Sample items.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] sample_value, [15:8] cell_x, [23:16] cell_y, [29:24] plane_index, [31:30] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result items.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] composite_value, [15:8] out_x, [23:16] out_y
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // last_cell
    output logic                       m_axis_tlast,
    // Configuration writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int X_CELLS = (GRID_WIDTH < AXIS_CELLS_MAX) ? GRID_WIDTH : AXIS_CELLS_MAX;
    localparam int Y_CELLS = (GRID_HEIGHT < AXIS_CELLS_MAX) ? GRID_HEIGHT : AXIS_CELLS_MAX;
    localparam int X_AW = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
    localparam int Y_AW = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
    localparam int ADDR_W = X_AW + Y_AW;

    // Configuration registers.
    logic [COORD_W-1:0]  win_x_first_reg;
    logic [COORD_W-1:0]  win_x_last_reg;
    logic [COORD_W-1:0]  win_y_first_reg;
    logic [COORD_W-1:0]  win_y_last_reg;
    logic [PCOUNT_W-1:0] plane_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_first_reg <= '0;
            win_x_last_reg  <= '1;
            win_y_first_reg <= '0;
            win_y_last_reg  <= '1;
            plane_count_reg <= PCOUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_X_FIRST: win_x_first_reg <= cfg_data[COORD_W-1:0];
                CFG_WINDOW_X_LAST:  win_x_last_reg  <= cfg_data[COORD_W-1:0];
                CFG_WINDOW_Y_FIRST: win_y_first_reg <= cfg_data[COORD_W-1:0];
                CFG_WINDOW_Y_LAST:  win_y_last_reg  <= cfg_data[COORD_W-1:0];
                CFG_PLANE_COUNT:    plane_count_reg <= cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input decode and filtering.
    logic [VALUE_W-1:0] in_value;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [PLANE_W-1:0] in_plane;
    logic               in_keep;
    logic               in_emit;
    logic               in_last;
    logic               in_accept;
    logic [ADDR_W-1:0]  in_addr;

    assign in_value = s_axis_tdata[VALUE_W-1:0];
    assign in_x     = s_axis_tdata[VALUE_W +: COORD_W];
    assign in_y     = s_axis_tdata[VALUE_W+COORD_W +: COORD_W];
    assign in_plane = s_axis_tdata[VALUE_W+2*COORD_W +: PLANE_W];

    always_comb
    begin
        in_keep = (win_x_first_reg <= win_x_last_reg) && (win_y_first_reg <= win_y_last_reg)
                  && (in_x >= win_x_first_reg) && (in_x <= win_x_last_reg)
                  && (in_y >= win_y_first_reg) && (in_y <= win_y_last_reg)
                  && (32'(in_x) < GRID_WIDTH) && (32'(in_y) < GRID_HEIGHT)
                  && ({1'b0, in_plane} < plane_count_reg)
                  && (32'(in_plane) < MAX_PLANES);
        in_emit = (({1'b0, in_plane} + PCOUNT_W'(1)) == plane_count_reg);
        in_last = (in_x == win_x_last_reg) && (in_y == win_y_last_reg);
        in_addr = {in_y[Y_AW-1:0], in_x[X_AW-1:0]};
    end

    // Pipeline registers.
    logic               s1_valid_reg, s1_valid_next;
    logic [VALUE_W-1:0] s1_value_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic               s1_first_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    logic               s2_valid_reg, s2_valid_next;
    logic [VALUE_W-1:0] s2_value_reg;
    logic [COORD_W-1:0] s2_x_reg;
    logic [COORD_W-1:0] s2_y_reg;
    logic               s2_first_reg;
    logic               s2_emit_reg;
    logic               s2_last_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;
    logic               s2_fwd_reg, s2_fwd_next;
    logic [VALUE_W-1:0] s2_fwd_value_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic               out_free;
    logic               s2_go;
    logic               s2_ready;
    logic               s1_ready;
    logic [VALUE_W-1:0] s2_stored;
    logic [VALUE_W-1:0] s2_cur;
    logic [VALUE_W-1:0] rd_data;
    logic               mem_we;

    always_comb
    begin
        out_free  = !out_valid_reg || m_axis_tready;
        s2_go     = s2_valid_reg && (!s2_emit_reg || out_free);
        s2_ready  = !s2_valid_reg || s2_go;
        s1_ready  = !s1_valid_reg || s2_ready;
        in_accept = s_axis_tvalid && s1_ready;
        mem_we    = s2_go;

        s2_stored = s2_fwd_reg ? s2_fwd_value_reg : rd_data;
        if (s2_first_reg)
        begin
            s2_cur = s2_value_reg;
        end
        else
        begin
            s2_cur = (s2_value_reg > s2_stored) ? s2_value_reg : s2_stored;
        end

        s1_valid_next = s1_ready ? (in_accept && in_keep) : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        // The store returns the old byte when the item ahead writes the same cell.
        s2_fwd_next   = s2_ready ? (s2_valid_reg && (s2_addr_reg == s1_addr_reg)) : s2_fwd_reg;
        if (s2_go && s2_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign s_axis_tready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s2_fwd_reg    <= s2_fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_value_reg <= in_value;
            s1_x_reg     <= in_x;
            s1_y_reg     <= in_y;
            s1_first_reg <= (in_plane == '0);
            s1_emit_reg  <= in_emit;
            s1_last_reg  <= in_last;
            s1_addr_reg  <= in_addr;
        end
        if (s2_ready)
        begin
            s2_value_reg     <= s1_value_reg;
            s2_x_reg         <= s1_x_reg;
            s2_y_reg         <= s1_y_reg;
            s2_first_reg     <= s1_first_reg;
            s2_emit_reg      <= s1_emit_reg;
            s2_last_reg      <= s1_last_reg;
            s2_addr_reg      <= s1_addr_reg;
            s2_fwd_value_reg <= s2_cur;
        end
        if (s2_go && s2_emit_reg)
        begin
            out_data_reg <= {s2_y_reg, s2_x_reg, s2_cur};
            out_last_reg <= s2_last_reg;
        end
    end

    mpc_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (s2_addr_reg),
        .wr_data (s2_cur),
        .rd_en   (s2_ready),
        .rd_addr (s1_addr_reg),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // A kept item always reaches the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && in_keep) |=> s1_valid_reg)
        else $error("kept input item did not enter the pipeline");

    // An emitting item held behind a stalled output must not move; its address and value stay.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_emit_reg && m_axis_tvalid && !m_axis_tready)
        |=> (s2_valid_reg && $stable(s2_addr_reg) && $stable(s2_value_reg)))
        else $error("stalled compositing stage advanced");

    // Forwarding may be armed while the compositing stage is empty, but the store is then not written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fwd_reg && !s2_valid_reg) |-> !mem_we)
        else $error("store written from an empty stage");

endmodule : max_projection_composite

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for max_projection_composite: a directed table, then random
// window projections, checked item by item against inline results or an in-bench max projection model.
// Depends on rtl/mpc_pkg.sv, rtl/mpc_store.sv and rtl/max_projection_composite.sv.
`timescale 1ns / 1ps

module testbench
    import mpc_pkg::*;
();

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 540;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PLANE_W-1:0] plane;
    } sample_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } pixel_t;

    // ROW_SILENT rows must cause no result; ROW_GIVEN rows carry their result inline.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_SILENT,
        ROW_GIVEN
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_index_t            cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        sample_t               smp;
        pixel_t                given;
    } step_row_t;

    localparam sample_t NO_SAMPLE = '0;
    localparam pixel_t  NO_PIXEL  = '0;
    localparam int      NUM_ROWS  = 41;

    // Columns: kind, register, register value, {value, x, y, plane}, {value, x, y, last}.
    localparam step_row_t DIRECTED [NUM_ROWS] = '{
        // Reset window covers the whole grid with a single plane.
        '{ROW_GIVEN,   CFG_WINDOW_X_FIRST, 8'd0, '{8'h00, 8'd0, 8'd0, 6'd0},
          '{8'h00, 8'd0, 8'd0, 1'b0}},
        '{ROW_GIVEN,   CFG_WINDOW_X_FIRST, 8'd0, '{8'hFF, 8'd255, 8'd255, 6'd0},
          '{8'hFF, 8'd255, 8'd255, 1'b1}},
        '{ROW_GIVEN,   CFG_WINDOW_X_FIRST, 8'd0, '{8'hA5, 8'd255, 8'd0, 6'd0},
          '{8'hA5, 8'd255, 8'd0, 1'b0}},
        '{ROW_GIVEN,   CFG_WINDOW_X_FIRST, 8'd0, '{8'h5A, 8'd0, 8'd255, 6'd0},
          '{8'h5A, 8'd0, 8'd255, 1'b0}},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'h5A, 8'd0, 8'd255, 6'd1}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'h01, 8'h55, 8'hAA, 6'd63}, NO_PIXEL},
        // Two by one window, two planes.
        '{ROW_CFG,     CFG_WINDOW_X_FIRST, 8'd10, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_X_LAST,  8'd11, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_Y_FIRST, 8'd20, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_Y_LAST,  8'd20, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_PLANE_COUNT,    8'd2,  NO_SAMPLE, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd7,   8'd10, 8'd20, 6'd0}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd9,   8'd11, 8'd20, 6'd0}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd3,   8'd9,  8'd20, 6'd0}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd200, 8'd12, 8'd20, 6'd0}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd8,   8'd10, 8'd21, 6'd0}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd8,   8'd10, 8'd19, 6'd0}, NO_PIXEL},
        '{ROW_PREDICT, CFG_WINDOW_X_FIRST, 8'd0, '{8'd5,   8'd10, 8'd20, 6'd1}, NO_PIXEL},
        '{ROW_PREDICT, CFG_WINDOW_X_FIRST, 8'd0, '{8'd200, 8'd11, 8'd20, 6'd1}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd0,   8'd10, 8'd20, 6'd2}, NO_PIXEL},
        // No planes at all.
        '{ROW_CFG,     CFG_PLANE_COUNT,    8'd0,  NO_SAMPLE, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd50,  8'd10, 8'd20, 6'd0}, NO_PIXEL},
        // More planes than exist: cells are composited, nothing comes out.
        '{ROW_CFG,     CFG_PLANE_COUNT,    8'd127, NO_SAMPLE, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd50,  8'd10, 8'd20, 6'd0}, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd60,  8'd11, 8'd20, 6'd63}, NO_PIXEL},
        '{ROW_CFG,     CFG_PLANE_COUNT,    8'd2,  NO_SAMPLE, NO_PIXEL},
        '{ROW_PREDICT, CFG_WINDOW_X_FIRST, 8'd0, '{8'd40,  8'd10, 8'd20, 6'd1}, NO_PIXEL},
        '{ROW_PREDICT, CFG_WINDOW_X_FIRST, 8'd0, '{8'd0,   8'd11, 8'd20, 6'd1}, NO_PIXEL},
        // Inverted window on the column axis, then on the row axis.
        '{ROW_CFG,     CFG_WINDOW_X_FIRST, 8'd200, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_X_LAST,  8'd100, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_PLANE_COUNT,    8'd1,   NO_SAMPLE, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd9,   8'd150, 8'd20, 6'd0}, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_X_FIRST, 8'd0,   NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_X_LAST,  8'd255, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_Y_FIRST, 8'd255, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_Y_LAST,  8'd254, NO_SAMPLE, NO_PIXEL},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd9,   8'd3,  8'd255, 6'd0}, NO_PIXEL},
        // Single cell window in the far corner.
        '{ROW_CFG,     CFG_WINDOW_X_FIRST, 8'd255, NO_SAMPLE, NO_PIXEL},
        '{ROW_CFG,     CFG_WINDOW_Y_LAST,  8'd255, NO_SAMPLE, NO_PIXEL},
        '{ROW_GIVEN,   CFG_WINDOW_X_FIRST, 8'd0, '{8'd128, 8'd255, 8'd255, 6'd0},
          '{8'd128, 8'd255, 8'd255, 1'b1}},
        '{ROW_SILENT,  CFG_WINDOW_X_FIRST, 8'd0, '{8'd1,   8'd254, 8'd255, 6'd0}, NO_PIXEL}
    };

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index     = CFG_WINDOW_X_FIRST;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Projection model state and its copy of the window registers.
    logic [VALUE_W-1:0]  peak_store   [0:65535];
    bit                  cell_defined [0:65535];
    logic [COORD_W-1:0]  x_lo = 8'd0;
    logic [COORD_W-1:0]  x_hi = 8'd255;
    logic [COORD_W-1:0]  y_lo = 8'd0;
    logic [COORD_W-1:0]  y_hi = 8'd255;
    logic [PCOUNT_W-1:0] depth_planes = 7'd1;

    pixel_t pending_pixels [$];
    int     error_count     = 0;
    int     cycle_count     = 0;
    int     projected_items = 0;
    int     send_idle_pct   = 37;
    int     recv_idle_pct   = 88;
    bit     cfg_open        = 1'b0;

    max_projection_composite i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic bit in_projection(sample_t s);
        return x_lo <= x_hi && y_lo <= y_hi
            && s.x >= x_lo && s.x <= x_hi && s.y >= y_lo && s.y <= y_hi
            && {1'b0, s.plane} < depth_planes;
    endfunction

    // A composited sample above plane 0 reads its cell, which must have been written.
    function automatic bit reads_unwritten(sample_t s);
        return in_projection(s) && s.plane != '0 && !cell_defined[{s.y, s.x}];
    endfunction

    function automatic bit project_sample(input sample_t s, output pixel_t px);
        logic [VALUE_W-1:0] peak;
        px = '0;
        if (!in_projection(s))
            return 1'b0;
        peak = s.value;
        if (s.plane != '0 && peak_store[{s.y, s.x}] > peak)
            peak = peak_store[{s.y, s.x}];
        peak_store[{s.y, s.x}] = peak;
        if (s.plane == '0)
            cell_defined[{s.y, s.x}] = 1'b1;
        if ({1'b0, s.plane} + 7'd1 != depth_planes)
            return 1'b0;
        px = '{peak, s.x, s.y, (s.x == x_hi && s.y == y_hi)};
        return 1'b1;
    endfunction

    function automatic int field_mismatch(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic int place_window(int span);
        case ($urandom_range(3))
            0: return 0;
            1: return AXIS_CELLS_MAX - span;
            default: return $urandom_range(0, AXIS_CELLS_MAX - span);
        endcase
    endfunction

    // Half the noise lands on or just around the window, half anywhere on the grid.
    function automatic sample_t noise_sample(int x0, int w, int y0, int h);
        sample_t s;
        s.value = 8'($urandom);
        s.plane = 6'($urandom);
        if ($urandom_range(1) == 1)
        begin
            s.x = 8'(x0 - 1 + $urandom_range(0, w + 1));
            s.y = 8'(y0 - 1 + $urandom_range(0, h + 1));
        end
        else
        begin
            s.x = 8'($urandom);
            s.y = 8'($urandom);
        end
        return s;
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result item with none expected: tdata %h, tlast %b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                error_count += field_mismatch("composite_value", want.value, m_axis_tdata[7:0]);
                error_count += field_mismatch("out_x", want.x, m_axis_tdata[15:8]);
                error_count += field_mismatch("out_y", want.y, m_axis_tdata[23:16]);
                error_count += field_mismatch("last_cell", {7'd0, want.last},
                                              {7'd0, m_axis_tlast});
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_open = 1'b1;
        case (idx)
            CFG_WINDOW_X_FIRST: x_lo = val;
            CFG_WINDOW_X_LAST:  x_hi = val;
            CFG_WINDOW_Y_FIRST: y_lo = val;
            CFG_WINDOW_Y_LAST:  y_hi = val;
            CFG_PLANE_COUNT:    depth_planes = val[PCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input sample_t smp, input row_kind_t how, input pixel_t given);
        sample_t s;
        pixel_t  px;
        bit      emits;
        s = smp;
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (reads_unwritten(s))
            s.plane = '0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, s.plane, s.y, s.x, s.value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (in_projection(s))
            projected_items++;
        emits = project_sample(s, px);
        if (how == ROW_GIVEN)
            pending_pixels.push_back(given);
        else if (how == ROW_PREDICT && emits)
            pending_pixels.push_back(px);
    endtask

    // Ignored samples may still be in the pipeline after the last result, hence the settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_projection();
        int      kind;
        int      w;
        int      h;
        int      n_planes;
        int      x0;
        int      y0;
        int      a;
        int      b;
        bit      broken;
        sample_t s;
        kind = $urandom_range(99);
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        if (kind < 5)
        begin
            w = 1;
            h = 1;
        end
        n_planes = (kind < 5) ? MAX_PLANES : $urandom_range(1, 64 / (w * h));
        x0 = place_window(w);
        y0 = place_window(h);
        broken = (kind >= 15 && kind < 30);
        drain();
        write_reg(CFG_WINDOW_X_FIRST, 8'(x0));
        write_reg(CFG_WINDOW_X_LAST, 8'(x0 + w - 1));
        write_reg(CFG_WINDOW_Y_FIRST, 8'(y0));
        write_reg(CFG_WINDOW_Y_LAST, 8'(y0 + h - 1));
        write_reg(CFG_PLANE_COUNT, 8'(n_planes));
        if (kind >= 5 && kind < 15)
        begin
            if (kind < 9)
            begin
                a = $urandom_range(1, 255);
                b = $urandom_range(0, a - 1);
                if (kind < 7)
                begin
                    write_reg(CFG_WINDOW_X_FIRST, 8'(a));
                    write_reg(CFG_WINDOW_X_LAST, 8'(b));
                end
                else
                begin
                    write_reg(CFG_WINDOW_Y_FIRST, 8'(a));
                    write_reg(CFG_WINDOW_Y_LAST, 8'(b));
                end
            end
            else if (kind < 11)
                write_reg(CFG_PLANE_COUNT, 8'd0);
            else
                write_reg(CFG_PLANE_COUNT, 8'($urandom_range(MAX_PLANES + 1, 127)));
            repeat (24)
                send_sample(noise_sample(x0, w, y0, h), ROW_PREDICT, NO_PIXEL);
            return;
        end
        // Planes in ascending order, each a raster scan of the window.
        for (int p = 0; p < n_planes; p++)
        begin
            for (int yy = 0; yy < h; yy++)
            begin
                for (int xx = 0; xx < w; xx++)
                begin
                    if ($urandom_range(99) < 8)
                        send_sample(noise_sample(x0, w, y0, h), ROW_PREDICT, NO_PIXEL);
                    if (!(broken && $urandom_range(99) < 20))
                    begin
                        s.value = 8'($urandom);
                        s.x     = 8'(x0 + xx);
                        s.y     = 8'(y0 + yy);
                        s.plane = 6'(p);
                        send_sample(s, ROW_PREDICT, NO_PIXEL);
                    end
                    if ($urandom_range(999) < 4)
                        drain();
                end
            end
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("[max_projection_composite] ERROR");
        $finish;
    end

    initial
    begin
        step_row_t row;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
            begin
                if (i == 0 || DIRECTED[i - 1].kind != ROW_CFG)
                    drain();
                write_reg(row.cfg_idx, row.cfg_val);
            end
            else
                send_sample(row.smp, row.kind, row.given);
        end
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 37 : 0;
            while (projected_items < PHASE_ITEMS * (phase + 1))
                run_projection();
        end
        drain();
        if (error_count == 0)
            $display("[max_projection_composite] OK");
        else
            $display("[max_projection_composite] ERROR");
        $finish;
    end

endmodule
